### design/sfp_pkg.sv
// shared types and character codes for the sensor command frame parser
package sfp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned FieldW  = 2;
  localparam int unsigned DigitW  = 4;
  localparam int unsigned AccW    = 10;
  localparam int unsigned OutW    = 8;

  // frame characters
  localparam logic [ByteW-1:0] ChStart = 8'h23;  // '#'
  localparam logic [ByteW-1:0] ChEnd   = 8'h21;  // '!'
  localparam logic [ByteW-1:0] ChZero  = 8'h30;  // '0'
  localparam logic [ByteW-1:0] ChNine  = 8'h39;  // '9'
  localparam logic [ByteW-1:0] ChA     = 8'h41;
  localparam logic [ByteW-1:0] ChP     = 8'h50;
  localparam logic [ByteW-1:0] ChL     = 8'h4C;
  localparam logic [ByteW-1:0] ChR     = 8'h52;
  localparam logic [ByteW-1:0] ChT     = 8'h54;
  localparam logic [ByteW-1:0] ChH     = 8'h48;
  localparam logic [ByteW-1:0] ChC     = 8'h43;

  localparam logic [AccW-1:0] MaxSum = 10'd255;

  // result status
  localparam logic [FieldW-1:0] StTaken    = 2'd0;
  localparam logic [FieldW-1:0] StComplete = 2'd1;
  localparam logic [FieldW-1:0] StRejected = 2'd2;

  // command kinds
  localparam logic [FieldW-1:0] CmdReadAll  = 2'd0;
  localparam logic [FieldW-1:0] CmdReadOne  = 2'd1;
  localparam logic [FieldW-1:0] CmdList     = 2'd2;
  localparam logic [FieldW-1:0] CmdResetHis = 2'd3;

  // sensors
  localparam logic [FieldW-1:0] SenNone = 2'd0;
  localparam logic [FieldW-1:0] SenTemp = 2'd1;
  localparam logic [FieldW-1:0] SenHum  = 2'd2;
  localparam logic [FieldW-1:0] SenCo2  = 2'd3;

  typedef enum logic [2:0] {
    PS_IDLE = 3'd0,
    PS_HASH = 3'd1,
    PS_CMD  = 3'd2,
    PS_SENS = 3'd3,
    PS_D1   = 3'd4,
    PS_D2   = 3'd5,
    PS_D3   = 3'd6
  } parse_state_t;

endpackage

### design/sensor_command_frame_parser.sv
// top level of the sensor command frame parser
//
//  channel | dir | fields (tdata, low bit up)
//  s_*     | in  | rx_byte[7:0]
//  m_*     | out | status[1:0], command_kind[3:2], sensor[5:4], zero[7:6]
//
// one byte per cycle sustained while results are taken; a request's result passes through
// the input register, then parse logic into the result register.
// rst clears the parser state and both valid flags.
// a stall on m_tready holds the result and backs up into the input register;
// s_tready drops only when both registers are full and the result is not taken.
module sensor_command_frame_parser (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [sfp_pkg::ByteW-1:0] s_tdata,  // rx_byte[7:0]
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [sfp_pkg::OutW-1:0]  m_tdata   // status[1:0], command_kind[3:2], sensor[5:4]
);
  import sfp_pkg::*;

  // input register
  logic             in_valid;
  logic [ByteW-1:0] in_byte;

  // parser state
  parse_state_t      state, state_next;
  logic [FieldW-1:0] command_reg, command_reg_next;
  logic [FieldW-1:0] sensor_reg, sensor_reg_next;
  logic [ByteW-1:0]  running_sum, running_sum_next;
  logic [ByteW-1:0]  digit_value, digit_value_next;

  // result register
  logic              out_valid;
  logic [FieldW-1:0] out_status, out_kind, out_sensor;
  logic [FieldW-1:0] res_status, res_kind, res_sensor;

  logic              advance;
  logic              is_digit;
  logic              sensor_hit;
  logic [FieldW-1:0] sensor_code;
  logic              cmd_hit;
  logic [FieldW-1:0] cmd_code;
  logic [DigitW-1:0] digit;
  logic [AccW-1:0]   acc;

  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;

  assign is_digit = (in_byte >= ChZero) && (in_byte <= ChNine);
  assign digit    = DigitW'(in_byte - ChZero);
  // value*10 + digit as shifts and adds
  assign acc = AccW'({digit_value, 3'b000}) + AccW'({digit_value, 1'b0}) + AccW'(digit);

  always_comb begin
    cmd_hit  = 1'b1;
    cmd_code = CmdReadAll;
    case (in_byte)
      ChA:     cmd_code = CmdReadAll;
      ChP:     cmd_code = CmdReadOne;
      ChL:     cmd_code = CmdList;
      ChR:     cmd_code = CmdResetHis;
      default: cmd_hit  = 1'b0;
    endcase
  end

  always_comb begin
    sensor_hit  = 1'b1;
    sensor_code = SenNone;
    case (in_byte)
      ChT:     sensor_code = SenTemp;
      ChH:     sensor_code = SenHum;
      ChC:     sensor_code = SenCo2;
      default: sensor_hit  = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_next       = state;
    command_reg_next = command_reg;
    sensor_reg_next  = sensor_reg;
    running_sum_next = running_sum;
    digit_value_next = digit_value;
    if (in_byte == ChStart) begin
      state_next       = PS_HASH;
      command_reg_next = CmdReadAll;
      sensor_reg_next  = SenNone;
      running_sum_next = '0;
      digit_value_next = '0;
    end else if (in_byte == ChEnd) begin
      state_next = PS_IDLE;
    end else begin
      case (state)
        PS_HASH: begin
          if (cmd_hit) begin
            command_reg_next = cmd_code;
            running_sum_next = running_sum + in_byte;
            state_next       = PS_CMD;
          end else begin
            state_next = PS_IDLE;
          end
        end
        PS_CMD: begin
          // A takes no sensor letter, P needs one
          if (sensor_hit && command_reg != CmdReadAll) begin
            sensor_reg_next  = sensor_code;
            running_sum_next = running_sum + in_byte;
            state_next       = PS_SENS;
          end else if (is_digit && command_reg != CmdReadOne) begin
            digit_value_next = ByteW'(digit);
            state_next       = PS_D1;
          end else begin
            state_next = PS_IDLE;
          end
        end
        PS_SENS: begin
          if (is_digit) begin
            digit_value_next = ByteW'(digit);
            state_next       = PS_D1;
          end else begin
            state_next = PS_IDLE;
          end
        end
        PS_D1: begin
          if (is_digit) begin
            digit_value_next = acc[ByteW-1:0];
            state_next       = PS_D2;
          end else begin
            state_next = PS_IDLE;
          end
        end
        PS_D2: begin
          if (is_digit && acc <= MaxSum) begin
            digit_value_next = acc[ByteW-1:0];
            state_next       = PS_D3;
          end else begin
            state_next = PS_IDLE;
          end
        end
        default: state_next = PS_IDLE;
      endcase
    end
  end

  // result fields
  always_comb begin
    res_status = StTaken;
    res_kind   = CmdReadAll;
    res_sensor = SenNone;
    if (in_byte != ChStart && in_byte == ChEnd) begin
      if (state == PS_D3 && running_sum == digit_value) begin
        res_status = StComplete;
        res_kind   = command_reg;
        res_sensor = sensor_reg;
      end else begin
        res_status = StRejected;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      out_valid   <= 1'b0;
      state       <= PS_IDLE;
      command_reg <= CmdReadAll;
      sensor_reg  <= SenNone;
      running_sum <= '0;
      digit_value <= '0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        out_valid <= in_valid;
      end
      if (advance && in_valid) begin
        state       <= state_next;
        command_reg <= command_reg_next;
        sensor_reg  <= sensor_reg_next;
        running_sum <= running_sum_next;
        digit_value <= digit_value_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
    if (advance && in_valid) begin
      out_status <= res_status;
      out_kind   <= res_kind;
      out_sensor <= res_sensor;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_sensor, out_kind, out_status};

endmodule

### design/sfp_checker.sv
// port-level checks for the sensor command frame parser, with bind
module sfp_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [sfp_pkg::OutW-1:0]  m_tdata
);
  import sfp_pkg::*;

  logic [FieldW-1:0] st, kind, sen;
  assign st   = m_tdata[1:0];
  assign kind = m_tdata[3:2];
  assign sen  = m_tdata[5:4];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (st == StTaken || st == StComplete || st == StRejected))
    else $error("unknown status code");

  a_fields_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && st != StComplete |-> kind == CmdReadAll && sen == SenNone)
    else $error("command fields set without a completed command");

  a_read_one: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && st == StComplete && kind == CmdReadOne |-> sen != SenNone)
    else $error("read one sensor completed without a sensor");

  a_read_all: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && st == StComplete && kind == CmdReadAll |-> sen == SenNone)
    else $error("read all completed with a sensor");

endmodule

bind sensor_command_frame_parser sfp_checker u_sfp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### sim/tb.sv
// testbench for the sensor command frame parser: byte stream in, one checked result per byte
`timescale 1ns / 100ps

module tb;
  import sfp_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned RandomBytes = 1100;

  typedef struct packed {
    logic [FieldW-1:0] status;
    logic [FieldW-1:0] kind;
    logic [FieldW-1:0] sensor;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [ByteW-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OutW-1:0] m_tdata;  // status[1:0], command_kind[3:2], sensor[5:4], zero[7:6]

  sensor_command_frame_parser DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #10 clk = ~clk;

  // parser mirror
  parse_state_t     frame_state = PS_IDLE;
  logic [FieldW-1:0] frame_cmd = '0;
  logic [FieldW-1:0] frame_sensor = '0;
  logic [ByteW-1:0]  frame_sum = '0;
  logic [ByteW-1:0]  frame_digits = '0;

  frame_result_t pending_results[$];
  int unsigned   fail_count = 0;
  int unsigned   cycle_count = 0;
  int unsigned   bytes_sent = 0;
  int unsigned   burst_left = 0;
  bit            sender_gaps = 1'b0;

  function automatic int command_code(logic [ByteW-1:0] b);
    case (b)
      ChA:     return CmdReadAll;
      ChP:     return CmdReadOne;
      ChL:     return CmdList;
      ChR:     return CmdResetHis;
      default: return -1;
    endcase
  endfunction

  function automatic int sensor_code(logic [ByteW-1:0] b);
    case (b)
      ChT:     return SenTemp;
      ChH:     return SenHum;
      ChC:     return SenCo2;
      default: return -1;
    endcase
  endfunction

  function automatic bit is_digit(logic [ByteW-1:0] b);
    return b >= ChZero && b <= ChNine;
  endfunction

  // advance the mirror by one accepted byte and queue the result it must give
  task automatic parse_byte(input logic [ByteW-1:0] b);
    frame_result_t r;
    logic [AccW-1:0] v;
    int c;
    r = '{status: StTaken, kind: CmdReadAll, sensor: SenNone};
    if (b == ChStart) begin
      frame_state = PS_HASH;
      frame_cmd = '0;
      frame_sensor = '0;
      frame_sum = '0;
      frame_digits = '0;
    end else if (b == ChEnd) begin
      if (frame_state == PS_D3 && frame_sum == frame_digits) begin
        r.status = StComplete;
        r.kind = frame_cmd;
        r.sensor = frame_sensor;
      end else begin
        r.status = StRejected;
      end
      frame_state = PS_IDLE;
    end else begin
      case (frame_state)
        PS_HASH: begin
          c = command_code(b);
          if (c < 0) begin
            frame_state = PS_IDLE;
          end else begin
            frame_cmd = c[FieldW-1:0];
            frame_sum = frame_sum + b;
            frame_state = PS_CMD;
          end
        end
        PS_CMD: begin
          c = sensor_code(b);
          if (c >= 0 && frame_cmd != CmdReadAll) begin
            frame_sensor = c[FieldW-1:0];
            frame_sum = frame_sum + b;
            frame_state = PS_SENS;
          end else if (is_digit(b) && frame_cmd != CmdReadOne) begin
            frame_digits = b - ChZero;
            frame_state = PS_D1;
          end else begin
            frame_state = PS_IDLE;
          end
        end
        PS_SENS: begin
          if (is_digit(b)) begin
            frame_digits = b - ChZero;
            frame_state = PS_D1;
          end else begin
            frame_state = PS_IDLE;
          end
        end
        PS_D1: begin
          if (is_digit(b)) begin
            frame_digits = frame_digits * 8'd10 + (b - ChZero);
            frame_state = PS_D2;
          end else begin
            frame_state = PS_IDLE;
          end
        end
        PS_D2: begin
          v = AccW'(frame_digits) * 10'd10 + AccW'(b - ChZero);
          if (is_digit(b) && v <= MaxSum) begin
            frame_digits = v[ByteW-1:0];
            frame_state = PS_D3;
          end else begin
            frame_state = PS_IDLE;
          end
        end
        default: frame_state = PS_IDLE;
      endcase
    end
    pending_results.push_back(r);
  endtask

  // called at a rising edge; returns at the edge where the byte was taken
  task automatic drive_rx_byte(input logic [ByteW-1:0] b);
    if (sender_gaps && burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    parse_byte(b);
    bytes_sent++;
  endtask

  task automatic send_text(input string txt);
    foreach (txt[i]) drive_rx_byte(txt[i]);
  endtask

  // one frame with random content, mostly well formed
  task automatic send_random_frame();
    logic [ByteW-1:0] frame[$];
    logic [ByteW-1:0] cmd_chars[4] = '{ChA, ChP, ChL, ChR};
    logic [ByteW-1:0] sen_chars[3] = '{ChT, ChH, ChC};
    logic [ByteW-1:0] sum;
    int kind;
    int checksum;
    int pos;
    bit with_sensor;
    kind = $urandom_range(0, 3);
    case (kind)
      CmdReadAll: with_sensor = 1'b0;
      CmdReadOne: with_sensor = 1'b1;
      default:    with_sensor = $urandom_range(0, 1);
    endcase
    // now and then the wrong sensor arrangement for the command
    if ($urandom_range(0, 15) == 0) with_sensor = !with_sensor;
    frame.push_back(ChStart);
    frame.push_back(cmd_chars[kind]);
    sum = cmd_chars[kind];
    if (with_sensor) begin
      frame.push_back(sen_chars[$urandom_range(0, 2)]);
      sum = sum + frame[2];
    end
    case ($urandom_range(0, 9))
      0:       checksum = $urandom_range(200, 299);
      1:       checksum = (sum + $urandom_range(1, 255)) % 256;
      default: checksum = sum;
    endcase
    frame.push_back(ByteW'(ChZero + checksum / 100));
    frame.push_back(ByteW'(ChZero + (checksum / 10) % 10));
    frame.push_back(ByteW'(ChZero + checksum % 10));
    frame.push_back(ChEnd);
    case ($urandom_range(0, 11))
      0: begin
        pos = $urandom_range(1, frame.size() - 1);
        frame[pos] = ByteW'($urandom_range(0, 255));
      end
      1: frame.delete($urandom_range(1, frame.size() - 1));
      2: frame.delete(frame.size() - 1);
      default: ;
    endcase
    foreach (frame[i]) drive_rx_byte(frame[i]);
  endtask

  task automatic send_noise(input int unsigned count);
    repeat (count) drive_rx_byte(ByteW'($urandom_range(0, 255)));
  endtask

  task automatic test_directed_frames();
    sender_gaps = 1'b0;
    send_text("#A065!");
    send_text("#PT164!");
    drive_rx_byte(8'h00);
    drive_rx_byte(8'hFF);
    send_text("!");
    // restart in mid frame, then reset history of one sensor
    send_text("#L#RC149!");
    // third digit pushes the value above 255
    send_text("#A256!");
  endtask

  task automatic test_back_to_back_frames();
    sender_gaps = 1'b0;
    repeat (25) send_random_frame();
  endtask

  task automatic test_random_traffic();
    sender_gaps = 1'b1;
    while (bytes_sent < RandomBytes) begin
      if ($urandom_range(0, 3) == 0) send_noise($urandom_range(1, 4));
      send_random_frame();
      if ($urandom_range(0, 5) == 0) begin
        sender_gaps = !sender_gaps;
        burst_left = 0;
      end
    end
  endtask

  // receiver stalls: cycles through ready, random, periodic and heavy phases
  always @(posedge clk) begin
    case (cycle_count[8:7])
      2'd0:    m_tready <= 1'b1;
      2'd1:    m_tready <= ($urandom_range(0, 3) != 0);
      2'd2:    m_tready <= (cycle_count % 3 != 0);
      default: m_tready <= ($urandom_range(0, 2) == 0);
    endcase
  end

  always @(posedge clk) begin
    frame_result_t want;
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected request result 0x%02h", m_tdata);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[1:0] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_tdata[1:0]);
          fail_count++;
        end
        if (m_tdata[3:2] !== want.kind) begin
          $error("command_kind: expected %0d, got %0d", want.kind, m_tdata[3:2]);
          fail_count++;
        end
        if (m_tdata[5:4] !== want.sensor) begin
          $error("sensor: expected %0d, got %0d", want.sensor, m_tdata[5:4]);
          fail_count++;
        end
        if (m_tdata[7:6] !== 2'b00) begin
          $error("padding: expected 0, got %0d", m_tdata[7:6]);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed_frames();
    test_back_to_back_frames();
    test_random_traffic();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
design/sfp_pkg.sv
design/sensor_command_frame_parser.sv
design/sfp_checker.sv
sim/tb.sv
